@@ sv/dmct_pkg.sv @@
// shared constants, types and helpers for the direct-mapped cache tag lookup
package dmct_pkg;

    localparam int ADDR_W          = 32;
    localparam int LINE_W          = 16;
    localparam int CNT_W           = 32;
    localparam int DEF_INDEX_BITS  = 16;
    localparam int DEF_TAG_BITS    = 14;
    localparam int DEF_OFFSET_BITS = 2;

    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_cnt CNT_MAX = '1;

    typedef struct packed {
        logic hit;
        logic miss;
    } t_cnt_evt;

    typedef struct packed {
        t_cnt hit;
        t_cnt miss;
    } t_cnt_pair;

    function automatic t_cnt sat_inc(input t_cnt v);
        return (v == CNT_MAX) ? v : v + t_cnt'(1);
    endfunction

endpackage

@@ sv/dmct_tag_ram.sv @@
// single-port-write, registered-read memory holding valid bit and tag per line
module dmct_tag_ram #(
    parameter int ADDR_BITS = 16,
    parameter int DATA_BITS = 15
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/dmct_counters.sv @@
// saturating hit and miss counters
module dmct_counters (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dmct_pkg::t_cnt_evt  i_evt,
    output dmct_pkg::t_cnt_pair o_cur,
    output dmct_pkg::t_cnt_pair o_nxt
);
    import dmct_pkg::*;

    t_cnt_pair r_cnt;
    t_cnt_pair n_cnt;

    always_comb begin
        n_cnt      = r_cnt;
        if (i_evt.hit) begin
            n_cnt.hit = sat_inc(r_cnt.hit);
        end
        if (i_evt.miss) begin
            n_cnt.miss = sat_inc(r_cnt.miss);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_cur = r_cnt;
    assign o_nxt = n_cnt;

endmodule

@@ sv/direct_mapped_cache_tag_lookup_core.sv @@
// top level: lookup sequencer, clearing pass and result register of the tag lookup
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_address
//  out     | output    | o_out_valid / i_out_stall | o_hit, o_line_index, o_hit_total,
//          |           |                           | o_miss_total
//
// each beat passes two steps: tag memory read, then compare, write-back and result load
// after reset a clearing pass walks every line of the tag memory with input stalled
// a result waiting under stall does not block the next input beat; the lookup waits
// only when the result register is still full
module direct_mapped_cache_tag_lookup_core #(
    parameter int INDEX_BITS  = dmct_pkg::DEF_INDEX_BITS,
    parameter int TAG_BITS    = dmct_pkg::DEF_TAG_BITS,
    parameter int OFFSET_BITS = dmct_pkg::DEF_OFFSET_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [dmct_pkg::ADDR_W-1:0] i_address,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_hit,
    output logic [dmct_pkg::LINE_W-1:0] o_line_index,
    output logic [dmct_pkg::CNT_W-1:0]  o_hit_total,
    output logic [dmct_pkg::CNT_W-1:0]  o_miss_total
);
    import dmct_pkg::*;

    localparam int SPAN   = OFFSET_BITS + INDEX_BITS + TAG_BITS;
    localparam int DATA_W = TAG_BITS + 1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    t_state                r_state;
    logic [INDEX_BITS-1:0] r_clr_idx;
    logic [INDEX_BITS-1:0] r_idx;
    logic [TAG_BITS-1:0]   r_tag;
    logic                  r_out_valid;
    logic                  r_hit;
    logic [LINE_W-1:0]     r_line;
    t_cnt                  r_hit_total;
    t_cnt                  r_miss_total;

    logic [SPAN+ADDR_W-1:0]       w_addr_ext;
    logic [INDEX_BITS-1:0]        w_idx;
    logic [TAG_BITS-1:0]          w_tag;
    logic [LINE_W+INDEX_BITS-1:0] w_idx_ext;
    logic                         w_accept;
    logic                         w_out_free;
    logic                         w_load;
    logic                         w_hit;
    logic                         w_ram_we;
    logic [INDEX_BITS-1:0]        w_ram_waddr;
    logic [DATA_W-1:0]            w_ram_wdata;
    logic [DATA_W-1:0]            w_ram_rdata;
    t_cnt_evt                     w_evt;
    t_cnt_pair                    w_cnt_cur;
    t_cnt_pair                    w_cnt_nxt;

    // address split, bits beyond the address read as zero
    assign w_addr_ext = {{SPAN{1'b0}}, i_address};
    assign w_idx      = w_addr_ext[OFFSET_BITS +: INDEX_BITS];
    assign w_tag      = w_addr_ext[OFFSET_BITS + INDEX_BITS +: TAG_BITS];
    assign w_idx_ext  = {{LINE_W{1'b0}}, r_idx};

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load     = (r_state == ST_LOOKUP) && w_out_free;

    assign w_hit = w_ram_rdata[TAG_BITS] && (w_ram_rdata[TAG_BITS-1:0] == r_tag);

    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = r_idx;
        w_ram_wdata = {1'b1, r_tag};
        case (r_state)
            ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_idx;
                w_ram_wdata = '0;
            end
            ST_LOOKUP: begin
                w_ram_we = w_load && !w_hit;
            end
            default: begin
                w_ram_we = 1'b0;
            end
        endcase
    end

    assign w_evt.hit  = w_load && w_hit;
    assign w_evt.miss = w_load && !w_hit;

    dmct_tag_ram #(
        .ADDR_BITS (INDEX_BITS),
        .DATA_BITS (DATA_W)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_accept),
        .i_raddr (w_idx),
        .o_rdata (w_ram_rdata)
    );

    dmct_counters u_counters (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (w_evt),
        .o_cur   (w_cnt_cur),
        .o_nxt   (w_cnt_nxt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + INDEX_BITS'(1);
                    if (r_clr_idx == {INDEX_BITS{1'b1}}) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_idx   <= w_idx;
                        r_tag   <= w_tag;
                        r_state <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (w_load) begin
                r_out_valid  <= 1'b1;
                r_hit        <= w_hit;
                r_line       <= w_idx_ext[LINE_W-1:0];
                r_hit_total  <= w_cnt_nxt.hit;
                r_miss_total <= w_cnt_nxt.miss;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_hit;
    assign o_line_index = r_line;
    assign o_hit_total  = r_hit_total;
    assign o_miss_total = r_miss_total;

    a_accept_to_lookup: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_LOOKUP)
    ) else $error("input beat did not start a lookup");

    a_counts_move: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (w_cnt_cur.hit != $past(w_cnt_cur.hit))
                || (w_cnt_cur.miss != $past(w_cnt_cur.miss))
                || (w_cnt_cur.hit == CNT_MAX) || (w_cnt_cur.miss == CNT_MAX)
    ) else $error("result beat left both counters unchanged");

    a_counts_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !w_load |=> $stable(w_cnt_cur)
    ) else $error("counter changed without a result beat");

    a_writeback_on_miss: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_ram_we && (r_state == ST_LOOKUP)) |=> (o_out_valid && !o_hit)
    ) else $error("tag write-back without a miss result");

endmodule

@@ tb/sv/direct_mapped_cache_tag_lookup_core_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the direct-mapped cache tag lookup core
module direct_mapped_cache_tag_lookup_core_tb;
    import dmct_pkg::*;

    localparam int TAG_W        = DEF_TAG_BITS;
    localparam int IDX_W        = DEF_INDEX_BITS;
    localparam int OFF_W        = DEF_OFFSET_BITS;
    localparam int RANDOM_BEATS = 535;
    localparam int SETTLE_LIMIT = 20000;

    typedef struct packed {
        logic              hit;
        logic [LINE_W-1:0] line_index;
        logic [CNT_W-1:0]  hit_total;
        logic [CNT_W-1:0]  miss_total;
    } t_lookup_res;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic [ADDR_W-1:0] i_address;
    logic              o_in_stall;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_hit;
    logic [LINE_W-1:0] o_line_index;
    logic [CNT_W-1:0]  o_hit_total;
    logic [CNT_W-1:0]  o_miss_total;

    logic [ADDR_W-1:0] addr_pending [$];
    t_lookup_res       lookup_expected [$];

    logic [TAG_W-1:0]  tag_mem [0:(1 << IDX_W)-1];
    bit                line_valid [0:(1 << IDX_W)-1];
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  miss_count;

    int total_beats;
    int beats_sent;
    int beats_accepted;
    int error_count;
    bit beat_taken;

    direct_mapped_cache_tag_lookup_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_address    (i_address),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hit        (o_hit),
        .o_line_index (o_line_index),
        .o_hit_total  (o_hit_total),
        .o_miss_total (o_miss_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void queue_addr(input logic [ADDR_W-1:0] addr);
        addr_pending = {addr_pending, addr};
    endfunction

    function automatic t_lookup_res predict_lookup(input logic [ADDR_W-1:0] addr);
        logic [IDX_W-1:0] line;
        logic [TAG_W-1:0] tag;
        t_lookup_res      res;
        line = addr[OFF_W +: IDX_W];
        tag  = addr[OFF_W + IDX_W +: TAG_W];
        res.hit = line_valid[line] && (tag_mem[line] == tag);
        if (res.hit) begin
            if (hit_count != CNT_MAX)
                hit_count = hit_count + CNT_W'(1);
        end else begin
            if (miss_count != CNT_MAX)
                miss_count = miss_count + CNT_W'(1);
            tag_mem[line]    = tag;
            line_valid[line] = 1'b1;
        end
        res.line_index = line;
        res.hit_total  = hit_count;
        res.miss_total = miss_count;
        return res;
    endfunction

    always @(negedge i_clk) begin : drive
        int phase;
        int in_idle_pct;
        int out_idle_pct;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            phase = (total_beats > 0) ? (beats_sent * 3) / total_beats : 2;
            if (phase > 2)
                phase = 2;
            in_idle_pct  = (phase == 0) ? 28 : (phase == 1) ? 72 : 0;
            out_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 28 : 0;
            if (!i_in_valid || beat_taken) begin
                if (addr_pending.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                    i_address  <= addr_pending.pop_front();
                    i_in_valid <= 1'b1;
                    beats_sent++;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check
        t_lookup_res want;
        beat_taken = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                beat_taken = 1'b1;
                beats_accepted++;
                lookup_expected = {lookup_expected, predict_lookup(i_address)};
            end
            if (o_out_valid && !i_out_stall) begin
                if (lookup_expected.size() == 0) begin
                    $error("unexpected result beat, line_index %0h", o_line_index);
                    error_count++;
                end else begin
                    want = lookup_expected.pop_front();
                    if (o_hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, o_hit);
                        error_count++;
                    end
                    if (o_line_index !== want.line_index) begin
                        $error("line_index: expected %0h, got %0h",
                               want.line_index, o_line_index);
                        error_count++;
                    end
                    if (o_hit_total !== want.hit_total) begin
                        $error("hit_total: expected %0d, got %0d",
                               want.hit_total, o_hit_total);
                        error_count++;
                    end
                    if (o_miss_total !== want.miss_total) begin
                        $error("miss_total: expected %0d, got %0d",
                               want.miss_total, o_miss_total);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin : stimulus
        logic [IDX_W-1:0]  idx_pool [0:31];
        logic [TAG_W-1:0]  tag_pool [0:3];
        logic [ADDR_W-1:0] addr;
        int                settle;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_out_stall    = 1'b0;
        i_address      = '0;
        hit_count      = '0;
        miss_count     = '0;
        beats_sent     = 0;
        beats_accepted = 0;
        error_count    = 0;
        beat_taken     = 1'b0;

        // line 0 with tag 0 matches the cleared store but is not yet valid
        queue_addr(32'h0000_0000);
        queue_addr(32'h0000_0000);
        queue_addr(32'h0000_0003);
        queue_addr(32'hFFFF_FFFF);
        queue_addr(32'hFFFF_FFFC);
        queue_addr(32'h0003_FFFC);
        queue_addr(32'hFFFF_FFFF);
        queue_addr(32'hFFFC_0000);
        queue_addr(32'h0000_0001);
        queue_addr(32'h0004_0000);
        queue_addr(32'h0000_0004);
        queue_addr(32'h0000_0006);
        queue_addr(32'hAAAA_AAAA);
        queue_addr(32'hAAAA_AAA9);
        queue_addr(32'h5555_5555);
        queue_addr(32'h5555_5556);
        queue_addr(32'hAAAA_AAAA);

        // a small working set gives hits and conflict misses, the rest is noise
        foreach (idx_pool[k])
            idx_pool[k] = IDX_W'($urandom);
        foreach (tag_pool[k])
            tag_pool[k] = TAG_W'($urandom);
        repeat (RANDOM_BEATS) begin
            addr = $urandom;
            if ($urandom_range(9) < 7) begin
                addr[OFF_W +: IDX_W]         = idx_pool[5'($urandom_range(31))];
                addr[OFF_W + IDX_W +: TAG_W] = tag_pool[2'($urandom_range(3))];
            end
            queue_addr(addr);
        end
        total_beats = addr_pending.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_accepted < total_beats)
            @(negedge i_clk);
        settle = 0;
        while (lookup_expected.size() != 0 && settle < SETTLE_LIMIT) begin
            @(negedge i_clk);
            settle++;
        end
        repeat (8) @(negedge i_clk);

        if (error_count == 0 && lookup_expected.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
